### src/rs485_pkg.sv
//------------------------------------------------------------------------------
// rs485_pkg
// Shared types, constants and helpers of the RS-485 poll link controller.
//------------------------------------------------------------------------------
`default_nettype none
package rs485_pkg;
	localparam int MAX_SLOTS = 16;
	localparam int PIN_BITS = 16;
	localparam int SLOT_W = $clog2(MAX_SLOTS);

	localparam logic [1:0] FUNC_BYTE = 2'd0;
	localparam logic [1:0] FUNC_TX = 2'd1;
	localparam logic [1:0] FUNC_EOC = 2'd2;

	localparam logic [1:0] REG_SLOT_COUNT = 2'd0;
	localparam logic [1:0] REG_SLOT_ADDR = 2'd1;
	localparam logic [1:0] REG_CLEAN = 2'd2;
	localparam logic [1:0] REG_ERRS = 2'd3;

	localparam logic [2:0] TYPE_REPLY = 3'h2;
	localparam logic [3:0] TRAILER = 4'h3;
	localparam logic [2:0] TYPE_CMD = 3'h3;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
		logic [3:0] tx_slot;
		logic [15:0] out_bits;
		logic reset_request;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic [7:0] tx_byte;
		logic [3:0] slot;
		logic [15:0] in_bits;
		logic slot_comm_error;
		logic slot_perm_error;
		logic [31:0] slot_error_total;
		logic any_comm_error;
		logic any_perm_error;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [4:0] slot_count;
		logic [63:0] slot_addresses;
		logic [7:0] clean_cycles;
		logic [7:0] errors_to_latch;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the input item
		logic do_byte;   // run receive step
		logic tx_emit;   // present frame byte tx_idx
		logic [1:0] tx_idx;
		logic eoc_hyst;  // hysteresis on slot idx
		logic eoc_reset; // reset request and aggregate
		logic eoc_emit;  // report slot idx
		logic [SLOT_W-1:0] idx;
		logic idx_last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic [4:0] used;
	} status_t;

	function automatic logic [3:0] nib_xor4(input logic [31:0] w);
		logic [3:0] x;
		x = 4'h0;
		for (int i = 0; i < 8; i++) x ^= w[i*4 +: 4];
		return x;
	endfunction
endpackage
`default_nettype wire

### src/rs485_if.sv
//------------------------------------------------------------------------------
// rs485_if
// Valid/ready channel carrying one item of the poll link controller.
//------------------------------------------------------------------------------
`default_nettype none
interface rs485_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/rs485_ctrl.sv
//------------------------------------------------------------------------------
// rs485_ctrl
// Sequencer: walks frame bytes and slots, drives the datapath commands.
//------------------------------------------------------------------------------
`default_nettype none
module rs485_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire rs485_pkg::status_t status,
	output rs485_pkg::cmd_t cmd
);
	import rs485_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_TX = 6'b000100,
		ST_HYST = 6'b001000,
		ST_AGG = 6'b010000,
		ST_REPORT = 6'b100000
	} state_t;

	state_t state_q;
	logic [SLOT_W:0] idx_q;
	logic [1:0] tx_q;
	logic out_fire;
	logic [SLOT_W:0] idx_nx;
	logic idx_end;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_TX) || (state_q == ST_REPORT);
	assign out_fire = out_valid && out_ready;
	assign idx_nx = idx_q + 1'b1;
	assign idx_end = ({1'b0, idx_nx} == {1'b0, status.used});

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.idx = idx_q[SLOT_W-1:0];
		cmd.idx_last = idx_end;
		cmd.tx_idx = tx_q;
		cmd.do_byte = (state_q == ST_DECODE) && (status.func == FUNC_BYTE);
		cmd.tx_emit = (state_q == ST_TX);
		cmd.eoc_hyst = (state_q == ST_HYST);
		cmd.eoc_reset = (state_q == ST_AGG);
		cmd.eoc_emit = (state_q == ST_REPORT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			tx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					tx_q <= '0;
					if (in_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					priority if (status.func == FUNC_TX) state_q <= ST_TX;
					else if (status.func == FUNC_EOC && status.used != 5'd0)
						state_q <= ST_HYST;
					else state_q <= ST_IDLE;
				end
				ST_TX: begin
					if (out_fire) begin
						tx_q <= tx_q + 2'd1;
						if (tx_q == 2'd3) state_q <= ST_IDLE;
					end
				end
				ST_HYST: begin
					if (idx_end) begin
						idx_q <= '0;
						state_q <= ST_AGG;
					end else idx_q <= idx_nx;
				end
				ST_AGG: state_q <= ST_REPORT;
				ST_REPORT: begin
					if (out_fire) begin
						idx_q <= idx_nx;
						if (idx_end) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### src/rs485_dp.sv
//------------------------------------------------------------------------------
// rs485_dp
// Datapath: receive window, per-slot error state, frame and report build.
//------------------------------------------------------------------------------
`default_nettype none
module rs485_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire rs485_pkg::cfg_t cfg,
	input wire rs485_pkg::in_item_t item,
	input wire rs485_pkg::cmd_t cmd,
	output rs485_pkg::status_t status,
	output rs485_pkg::out_item_t result
);
	import rs485_pkg::*;

	in_item_t item_q;
	logic [23:0] win_q;
	logic [2:0] cnt_q;
	logic [PIN_BITS-1:0] lat_q [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] seen_q, comm_q, perm_q;
	logic [8:0] tim_q [MAX_SLOTS];
	logic [7:0] run_q [MAX_SLOTS];
	logic [31:0] tot_q [MAX_SLOTS];
	logic gcomm_q, gperm_q;

	logic [4:0] used;
	logic [3:0] addr [MAX_SLOTS];
	logic [31:0] frm;
	logic good;
	logic [MAX_SLOTS-1:0] hit;
	logic [MAX_SLOTS-1:0] first;
	logic [MAX_SLOTS-1:0] inuse;
	logic [15:0] txbits;
	logic [7:0] f0;
	logic [3:0] tnib;
	logic [7:0] tbyte;
	logic [8:0] h_tim;
	logic [7:0] h_run;
	logic h_comm, h_perm, h_cnt;
	logic agg_err, do_rst;

	assign used = (cfg.slot_count > 5'd16) ? 5'd16 : cfg.slot_count;
	assign status.func = item_q.func;
	assign status.used = used;

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			addr[i] = cfg.slot_addresses[i*4 +: 4];
			inuse[i] = (5'(i) < used);
		end
	end

	// receive frame check
	assign frm = {win_q, item_q.rx_byte};
	assign good = (cnt_q >= 3'd3) && (nib_xor4(frm) == 4'h0) &&
		(frm[26:24] == TYPE_REPLY) && (frm[3:0] == TRAILER);
	always_comb begin
		logic found;
		found = 1'b0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			hit[i] = inuse[i] && ({1'b0, addr[i]} == frm[31:27]);
			first[i] = hit[i] && !found;
			found = found | hit[i];
		end
	end

	// transmit frame
	assign txbits = gperm_q ? 16'h0 : item_q.out_bits;
	assign f0 = {1'b0, addr[item_q.tx_slot], TYPE_CMD};
	assign tnib = nib_xor4({f0, txbits, 8'h03});
	always_comb begin
		unique case (cmd.tx_idx)
			2'd0: tbyte = f0;
			2'd1: tbyte = txbits[15:8];
			2'd2: tbyte = txbits[7:0];
			default: tbyte = {tnib, TRAILER};
		endcase
	end

	// hysteresis of slot idx
	always_comb begin
		logic [8:0] t;
		logic [8:0] r;
		t = tim_q[cmd.idx];
		r = {1'b0, run_q[cmd.idx]};
		h_comm = comm_q[cmd.idx];
		h_perm = perm_q[cmd.idx];
		h_cnt = 1'b0;
		if (seen_q[cmd.idx]) begin
			if (t >= {1'b0, cfg.clean_cycles}) begin
				t = {1'b0, cfg.clean_cycles};
				r = '0;
				h_comm = 1'b0;
			end
		end else begin
			r = r + 9'd1;
			t = '0;
			h_cnt = 1'b1;
		end
		if (r >= {1'b0, cfg.errors_to_latch}) begin
			r = {1'b0, cfg.errors_to_latch};
			h_comm = 1'b1;
			h_perm = 1'b1;
		end
		h_run = r[7:0];
		h_tim = t + 9'd1;
	end

	assign agg_err = |(comm_q & inuse);
	assign do_rst = item_q.reset_request && !gcomm_q;

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			cnt_q <= '0;
			seen_q <= '0;
			comm_q <= '0;
			perm_q <= '0;
			gcomm_q <= 1'b0;
			gperm_q <= 1'b0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				lat_q[i] <= '0;
				tim_q[i] <= '0;
				run_q[i] <= '0;
				tot_q[i] <= '0;
			end
		end else begin
			if (cmd.do_byte) begin
				win_q <= frm[23:0];
				if (good) begin
					cnt_q <= '0;
					for (int i = 0; i < MAX_SLOTS; i++) begin
						if (first[i]) begin
							lat_q[i] <= frm[23:8];
							seen_q[i] <= 1'b1;
						end
					end
				end else if (cnt_q < 3'd4) cnt_q <= cnt_q + 3'd1;
			end
			if (cmd.tx_emit && cmd.tx_idx == 2'd3) seen_q[item_q.tx_slot] <= 1'b0;
			if (cmd.eoc_hyst) begin
				tim_q[cmd.idx] <= h_tim;
				run_q[cmd.idx] <= h_run;
				comm_q[cmd.idx] <= h_comm;
				perm_q[cmd.idx] <= h_perm;
				if (h_cnt) tot_q[cmd.idx] <= tot_q[cmd.idx] + 32'd1;
			end
			if (cmd.eoc_reset) begin
				gcomm_q <= agg_err;
				if (agg_err) gperm_q <= 1'b1;
				else if (do_rst) gperm_q <= 1'b0;
				if (do_rst) perm_q <= perm_q & ~inuse;
				if (agg_err || (gperm_q && !do_rst)) begin
					for (int i = 0; i < MAX_SLOTS; i++)
						if (inuse[i]) lat_q[i] <= '0;
				end
			end
		end
	end

	always_comb begin
		result = '0;
		if (cmd.tx_emit) begin
			result.tx_byte = tbyte;
			result.slot = item_q.tx_slot;
			result.last = (cmd.tx_idx == 2'd3);
		end else begin
			result.kind = 1'b1;
			result.slot = cmd.idx;
			result.in_bits = lat_q[cmd.idx];
			result.slot_comm_error = comm_q[cmd.idx];
			result.slot_perm_error = perm_q[cmd.idx];
			result.slot_error_total = tot_q[cmd.idx];
			result.any_comm_error = gcomm_q;
			result.any_perm_error = gperm_q;
			result.last = cmd.idx_last;
		end
	end
endmodule
`default_nettype wire

### src/rs485_io_link_controller_top.sv
// steps: a byte item runs the receive step; a transmit item gives 4 results;
// an end-of-cycle item updates n slots, aggregates, reports n (n used, max 16)
// throughput: one item at a time, set by the slot walk of the sequencer
// reset: arst_n clears all link and slot error state, registers take defaults
//------------------------------------------------------------------------------
// rs485_io_link_controller_top
// Master side of a four-byte framed RS-485 poll link to up to 16 I/O slots.
//------------------------------------------------------------------------------
`default_nettype none
module rs485_io_link_controller_top (
	input wire logic clk,
	input wire logic arst_n,
	rs485_if.sink in_ch,
	rs485_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	import rs485_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	status_t status;
	out_item_t result;
	logic [1:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_count <= 5'd1;
			cfg_q.slot_addresses <= '0;
			cfg_q.clean_cycles <= 8'd10;
			cfg_q.errors_to_latch <= 8'd5;
		end else if (psel && penable && pwrite && pready) begin
			unique case (ridx)
				REG_SLOT_COUNT: cfg_q.slot_count <= pwdata[4:0];
				REG_SLOT_ADDR: cfg_q.slot_addresses <= pwdata;
				REG_CLEAN: cfg_q.clean_cycles <= pwdata[7:0];
				default: cfg_q.errors_to_latch <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_SLOT_COUNT: prdata = {59'd0, cfg_q.slot_count};
			REG_SLOT_ADDR: prdata = cfg_q.slot_addresses;
			REG_CLEAN: prdata = {56'd0, cfg_q.clean_cycles};
			default: prdata = {56'd0, cfg_q.errors_to_latch};
		endcase
	end

	rs485_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.status(status), .cmd(cmd)
	);

	rs485_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .item(in_ch.data),
		.cmd(cmd), .status(status), .result(result)
	);

	assign out_ch.data = result;
endmodule
`default_nettype wire
